@@ hdl/stcm_pkg.sv @@
// Shared types and constants for the S-curve tone map pipeline.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package stcm_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int SLOPE_W       = 24;
    localparam int CFG_IDX_W     = 1;
    localparam int DEF_FRAC_BITS = 16;

    localparam logic [SLOPE_W-1:0]  SLOPE_RESET  = 24'h01_0000;
    localparam logic [SAMPLE_W-1:0] THRESH_RESET = 16'h8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOPE     = 1'b0,
        CFG_THRESHOLD = 1'b1
    } cfg_reg_t;

    // Valid bit and branch flag that travel with each item between units.
    typedef struct packed {
        logic valid;
        logic upper;
    } tag_t;

endpackage

`default_nettype wire

@@ hdl/stcm_front.sv @@
// Front end: clamp, branch select, products, denominator and rounded numerator.
// Four register stages. Depends on stcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stcm_front #(
    parameter int FRAC_BITS = stcm_pkg::DEF_FRAC_BITS,
    parameter int NUM_W     = 33,
    parameter int DEN_W     = 26
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [stcm_pkg::SAMPLE_W-1:0] sample_in,
    input  wire logic [stcm_pkg::SLOPE_W-1:0]  slope,
    input  wire logic [stcm_pkg::SAMPLE_W-1:0] threshold,
    input  wire logic                          down_ready,
    output stcm_pkg::tag_t                     out_tag,
    output logic [NUM_W-1:0]                   out_num,
    output logic [DEN_W-1:0]                   out_den
);
    import stcm_pkg::*;

    localparam int CW  = ((FRAC_BITS > SAMPLE_W) ? FRAC_BITS : SAMPLE_W) + 1;
    localparam int UW  = FRAC_BITS + 1;
    localparam int PSW = SLOPE_W + FRAC_BITS;
    localparam int PNW = 2 * UW;

    function automatic logic [UW-1:0] clamp_unit(input logic [SAMPLE_W-1:0] v);
        logic [CW-1:0] ve;
        logic [CW-1:0] one_c;
        ve    = CW'(v);
        one_c = CW'(1) << FRAC_BITS;
        return (ve >= one_c) ? UW'(one_c - CW'(1)) : UW'(ve);
    endfunction

    logic [UW-1:0]        x_c;
    logic [UW-1:0]        t_c;
    logic [UW-1:0]        one_u;
    logic                 upper_c;
    logic [FRAC_BITS-1:0] diff_c;
    logic [UW-1:0]        pa_c;
    logic [UW-1:0]        pb_c;

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic                 up1_reg, up2_reg, up3_reg, up4_reg;
    logic [FRAC_BITS-1:0] d1_reg;
    logic [UW-1:0]        pa1_reg, pb1_reg, pb2_reg;
    logic [PSW-1:0]       ps2_reg;
    logic [PNW-1:0]       pn2_reg, pn3_reg;
    logic [DEN_W-1:0]     den3_reg, den4_reg;
    logic [NUM_W-1:0]     num4_reg;
    logic                 ld1, ld2, ld3, ld4;

    always_comb
    begin
        x_c     = clamp_unit(sample_in);
        t_c     = clamp_unit(threshold);
        one_u   = UW'(1) << FRAC_BITS;
        upper_c = (x_c >= t_c);
        diff_c  = upper_c ? FRAC_BITS'(x_c - t_c) : FRAC_BITS'(t_c - x_c);
        pa_c    = upper_c ? (one_u - t_c) : t_c;
        // Same term serves as numerator factor and denominator base.
        pb_c    = upper_c ? (one_u - x_c) : x_c;
    end

    assign ld4      = !v4_reg || down_ready;
    assign ld3      = !v3_reg || ld4;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= in_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1 && in_valid)
        begin
            up1_reg <= upper_c;
            d1_reg  <= diff_c;
            pa1_reg <= pa_c;
            pb1_reg <= pb_c;
        end
        if (ld2 && v1_reg)
        begin
            up2_reg <= up1_reg;
            ps2_reg <= PSW'(slope) * PSW'(d1_reg);
            pn2_reg <= PNW'(pa1_reg) * PNW'(pb1_reg);
            pb2_reg <= pb1_reg;
        end
        if (ld3 && v2_reg)
        begin
            up3_reg  <= up2_reg;
            // Slope product truncated back to Q.F, plus one LSB of epsilon.
            den3_reg <= DEN_W'(pb2_reg) + DEN_W'(ps2_reg >> FRAC_BITS) + DEN_W'(1);
            pn3_reg  <= pn2_reg;
        end
        if (ld4 && v3_reg)
        begin
            up4_reg  <= up3_reg;
            den4_reg <= den3_reg;
            num4_reg <= NUM_W'(pn3_reg) + NUM_W'(den3_reg >> 1);
        end
    end

    assign out_tag = '{valid: v4_reg, upper: up4_reg};
    assign out_num = num4_reg;
    assign out_den = den4_reg;

endmodule

`default_nettype wire

@@ hdl/stcm_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on stcm_pkg for the item tag.
`timescale 1ns / 1ps
`default_nettype none

module stcm_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 26,
    parameter int QUO_W = 17
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire stcm_pkg::tag_t   in_tag,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  in_ready,
    input  wire logic             down_ready,
    output stcm_pkg::tag_t        out_tag,
    output logic [QUO_W-1:0]      quo
);
    import stcm_pkg::*;

    // Quotient is known to fit in QUO_W bits, so num >> QUO_W is below den.
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] bits_in;

    logic             valid_reg [1:QUO_W];
    logic             upper_reg [1:QUO_W];
    logic [DEN_W-1:0] rem_reg   [1:QUO_W];
    logic [DEN_W-1:0] den_reg   [1:QUO_W];
    logic [QUO_W-1:0] bits_reg  [1:QUO_W];
    logic [QUO_W-1:0] quo_reg   [1:QUO_W];
    logic             stage_ld  [1:QUO_W+1];

    assign rem_in            = DEN_W'(num >> QUO_W);
    assign bits_in           = num[QUO_W-1:0];
    assign stage_ld[QUO_W+1] = down_ready;
    assign in_ready          = stage_ld[1];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        logic             src_valid;
        logic             src_upper;
        logic [DEN_W-1:0] src_rem;
        logic [DEN_W-1:0] src_den;
        logic [QUO_W-1:0] src_bits;
        logic [QUO_W-1:0] src_quo;
        logic [DEN_W:0]   shifted;
        logic [DEN_W:0]   diff;
        logic             take;

        if (k == 0)
        begin : g_first
            assign src_valid = in_tag.valid;
            assign src_upper = in_tag.upper;
            assign src_rem   = rem_in;
            assign src_den   = den;
            assign src_bits  = bits_in;
            assign src_quo   = '0;
        end
        else
        begin : g_next
            assign src_valid = valid_reg[k];
            assign src_upper = upper_reg[k];
            assign src_rem   = rem_reg[k];
            assign src_den   = den_reg[k];
            assign src_bits  = bits_reg[k];
            assign src_quo   = quo_reg[k];
        end

        assign shifted       = {src_rem, src_bits[QUO_W-1]};
        assign diff          = shifted - {1'b0, src_den};
        assign take          = (shifted >= {1'b0, src_den});
        assign stage_ld[k+1] = !valid_reg[k+1] || stage_ld[k+2];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k+1] <= 1'b0;
            else if (stage_ld[k+1])
                valid_reg[k+1] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            if (stage_ld[k+1] && src_valid)
            begin
                upper_reg[k+1] <= src_upper;
                rem_reg[k+1]   <= take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                den_reg[k+1]   <= src_den;
                bits_reg[k+1]  <= src_bits << 1;
                quo_reg[k+1]   <= {src_quo[QUO_W-2:0], take};
            end
        end
    end

    assign out_tag = '{valid: valid_reg[QUO_W], upper: upper_reg[QUO_W]};
    assign quo     = quo_reg[QUO_W];

endmodule

`default_nettype wire

@@ hdl/stcm_post.sv @@
// Output stage: mirrors the upper branch, saturates, holds the result item.
// Depends on stcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stcm_post #(
    parameter int FRAC_BITS = stcm_pkg::DEF_FRAC_BITS,
    parameter int QUO_W     = 17
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire stcm_pkg::tag_t                in_tag,
    input  wire logic [QUO_W-1:0]              quo,
    output logic                               in_ready,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic [stcm_pkg::SAMPLE_W-1:0]      sample_out
);
    import stcm_pkg::*;

    logic [QUO_W-1:0]    one_q;
    logic [QUO_W-1:0]    res;
    logic                valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                ld;

    always_comb
    begin
        one_q = QUO_W'(1) << FRAC_BITS;
        priority if (in_tag.upper)
        begin
            // 1 - q, with a full-scale result pulled down to one LSB below 1.0
            priority if (quo >= one_q)
                res = '0;
            else if (quo == '0)
                res = one_q - QUO_W'(1);
            else
                res = one_q - quo;
        end
        else
        begin
            res = (quo >= one_q) ? (one_q - QUO_W'(1)) : quo;
        end
    end

    assign ld       = !valid_reg || !result_stall;
    assign in_ready = ld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ld)
            valid_reg <= in_tag.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ld && in_tag.valid)
            sample_reg <= SAMPLE_W'(res);
    end

    assign result_valid = valid_reg;
    assign sample_out   = sample_reg;

endmodule

`default_nettype wire

@@ hdl/s_curve_tone_map.sv @@
// S-curve tone map top level: configuration registers and the three pipeline units.
// Depends on stcm_pkg, stcm_front, stcm_div and stcm_post.
//
// Applies a bias/gain S-curve to each Q0.16 sample: below the threshold t the
// result is t*x/(x + s*(t-x) + eps), at or above it 1 - (1-t)(1-x)/((1-x) +
// s*(x-t) + eps), rounded to nearest and saturated to 0..1-LSB. The block takes
// one sample per clock while the output is not stalled and returns one result
// per sample, in order. The pipeline has four front-end stages for the clamp,
// the two products, the denominator and the rounded numerator, then
// FRAC_BITS + 1 stages of the restoring divider (one quotient bit each), then
// the output register. Each stage loads whenever the stage after it is empty or
// moving, so bubbles close up under output stall. Slope and threshold are read
// straight from their registers; write them only while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none

module s_curve_tone_map #(
    parameter int FRAC_BITS = stcm_pkg::DEF_FRAC_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           sample_valid,
    output logic                                sample_stall,
    input  wire logic [stcm_pkg::SAMPLE_W-1:0]  sample_in,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic [stcm_pkg::SAMPLE_W-1:0]       sample_out,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [stcm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [stcm_pkg::SLOPE_W-1:0]   cfg_data
);
    import stcm_pkg::*;

    localparam int DEN_W = ((SLOPE_W > FRAC_BITS) ? SLOPE_W : FRAC_BITS) + 2;
    localparam int NUM_W = ((2 * FRAC_BITS > DEN_W) ? 2 * FRAC_BITS : DEN_W) + 1;
    localparam int QUO_W = FRAC_BITS + 1;

    logic [SLOPE_W-1:0]  slope_reg;
    logic [SAMPLE_W-1:0] thresh_reg;

    logic                front_ready;
    tag_t                front_tag;
    logic [NUM_W-1:0]    front_num;
    logic [DEN_W-1:0]    front_den;
    logic                div_ready;
    tag_t                div_tag;
    logic [QUO_W-1:0]    div_quo;
    logic                post_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_reg  <= SLOPE_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SLOPE:     slope_reg  <= cfg_data;
                CFG_THRESHOLD: thresh_reg <= cfg_data[SAMPLE_W-1:0];
                default:       slope_reg  <= slope_reg;
            endcase
        end
    end

    assign sample_stall = !front_ready;

    stcm_front #(
        .FRAC_BITS (FRAC_BITS),
        .NUM_W     (NUM_W),
        .DEN_W     (DEN_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sample_valid),
        .in_ready   (front_ready),
        .sample_in  (sample_in),
        .slope      (slope_reg),
        .threshold  (thresh_reg),
        .down_ready (div_ready),
        .out_tag    (front_tag),
        .out_num    (front_num),
        .out_den    (front_den)
    );

    stcm_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .QUO_W (QUO_W)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_tag     (front_tag),
        .num        (front_num),
        .den        (front_den),
        .in_ready   (div_ready),
        .down_ready (post_ready),
        .out_tag    (div_tag),
        .quo        (div_quo)
    );

    stcm_post #(
        .FRAC_BITS (FRAC_BITS),
        .QUO_W     (QUO_W)
    ) u_post (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_tag       (div_tag),
        .quo          (div_quo),
        .in_ready     (post_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sample_out   (sample_out)
    );

endmodule

`default_nettype wire

@@ hdl/stcm_checker.sv @@
// Port-level checks for s_curve_tone_map, attached by bind.
// Depends on stcm_pkg and the s_curve_tone_map port list.
`timescale 1ns / 1ps
`default_nettype none

module stcm_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          sample_valid,
    input wire logic                          sample_stall,
    input wire logic                          result_valid,
    input wire logic                          result_stall,
    input wire logic [stcm_pkg::SAMPLE_W-1:0] sample_out,
    input wire logic                          cfg_valid,
    input wire logic                          cfg_ready
);
    import stcm_pkg::*;

    // A result item held under stall stays offered.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result item dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(sample_out))
        else $error("result payload changed while stalled");

    // With the output register empty every stage can load, so input never stalls.
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !sample_stall)
        else $error("input stalled while output register empty");

    a_cfg_always_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write refused");

endmodule

bind s_curve_tone_map stcm_checker u_stcm_checker (.*);

`default_nettype wire

@@ test/tb.sv @@
// Testbench for s_curve_tone_map: random and directed samples under several curve settings.
// Needs stcm_pkg and the s_curve_tone_map RTL; results are checked against an in-bench model.
`timescale 1ns / 1ps

module tb;

    import stcm_pkg::*;

    localparam int FB       = DEF_FRAC_BITS;
    localparam int IDLE_MAX = 3000;  // cycles with no handshake anywhere
    localparam int DRAIN    = 40;    // pipeline depth is FB + 6

    // Expected tone values, one per accepted sample, in order
    class tone_checker;
        logic [SLOPE_W-1:0]  slope;
        logic [SAMPLE_W-1:0] thresh;
        logic [SAMPLE_W-1:0] due[$];
        int                  errors;

        function new();
            slope  = SLOPE_RESET;
            thresh = THRESH_RESET;
            errors = 0;
        endfunction

        function void set_register(cfg_reg_t idx, logic [SLOPE_W-1:0] val);
            if (idx == CFG_SLOPE)
                slope = val;
            else
                thresh = val[SAMPLE_W-1:0];
        endfunction

        // Bias/gain curve in fixed point, 64-bit intermediates
        function logic [SAMPLE_W-1:0] tone_value(logic [SAMPLE_W-1:0] x_in);
            logic [63:0] one;
            logic [63:0] x;
            logic [63:0] t;
            logic [63:0] s;
            logic [63:0] den;
            logic [63:0] q;
            logic [63:0] res;
            one = 64'd1 << FB;
            x   = (x_in >= one) ? one - 1 : 64'(x_in);
            t   = (thresh >= one) ? one - 1 : 64'(thresh);
            s   = 64'(slope);
            if (x < t)
            begin
                den = x + ((s * (t - x)) >> FB) + 1;
                res = (t * x + (den >> 1)) / den;
            end
            else
            begin
                den = (one - x) + ((s * (x - t)) >> FB) + 1;
                q   = ((one - t) * (one - x) + (den >> 1)) / den;
                res = (q >= one) ? 64'd0 : one - q;
            end
            if (res >= one)
                res = one - 1;
            return res[SAMPLE_W-1:0];
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] x);
            due.push_back(tone_value(x));
        endfunction

        function void check_sample_out(logic [SAMPLE_W-1:0] got);
            logic [SAMPLE_W-1:0] want;
            if (due.size() == 0)
            begin
                $error("sample_out: no item expected, actual %0d", got);
                errors++;
                return;
            end
            want = due.pop_front();
            if (got !== want)
            begin
                $error("sample_out: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                sample_valid = 1'b0;
    logic                sample_stall;
    logic [SAMPLE_W-1:0] sample_in    = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [SAMPLE_W-1:0] sample_out;
    logic                cfg_valid    = 1'b0;
    logic                cfg_ready;
    cfg_reg_t            cfg_index    = CFG_SLOPE;
    logic [SLOPE_W-1:0]  cfg_data     = '0;

    tone_checker board = new();

    int  stall_pct = 0;
    int  gap_max   = 0;
    int  burst_left = 0;
    bit  hold_req  = 1'b0;
    int  idle_cycles = 0;

    always #6 clk = ~clk;

    s_curve_tone_map uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_in    (sample_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sample_out   (sample_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Monitors: values are read before this edge's updates land
    always @(posedge clk)
    begin
        if (sample_valid && !sample_stall)
            board.note_sample(sample_in);
        if (result_valid && !result_stall)
            board.check_sample_out(sample_out);
        if (cfg_valid && cfg_ready)
            board.set_register(cfg_index, cfg_data);
    end

    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Output side: random stall, plus a long hold-off when asked
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold = 300;
            end
            if (hold > 0)
            begin
                hold--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic set_curve(input logic [SLOPE_W-1:0] slope,
                             input logic [SAMPLE_W-1:0] thresh);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SLOPE;
        cfg_data  <= slope;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= SLOPE_W'(thresh);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] x);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        sample_valid <= 1'b1;
        sample_in    <= x;
        do @(posedge clk); while (sample_stall);
    endtask

    // Lower valid, then wait until every sent item has come back
    task automatic drain();
        sample_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] t);
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 55)
            v = $urandom_range(0, 65535);
        else if (r < 70)
            v = int'(t) + $urandom_range(0, 8) - 4;   // around the threshold
        else if (r < 85)
            v = 65535 - $urandom_range(0, 40);        // near full scale
        else if (r < 95)
            v = $urandom_range(0, 40);
        else
            v = ($urandom_range(1) != 0) ? 65535 : 0;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[SAMPLE_W-1:0];
    endfunction

    initial
    begin
        logic [SLOPE_W-1:0]  slope;
        logic [SAMPLE_W-1:0] thresh;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset curve, then corner settings
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
        drain();
        set_curve(24'h00_0000, 16'h0000);    // zero slope, threshold at zero
        send_sample(16'h0000);
        send_sample(16'h5555);
        send_sample(16'hFFFF);
        drain();
        set_curve(24'hFF_FFFF, 16'hFFFF);    // steepest, threshold at top
        send_sample(16'h0000);
        send_sample(16'hAAAA);
        send_sample(16'hFFFE);
        send_sample(16'hFFFF);
        drain();
        set_curve(24'h01_0000, 16'h0001);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'h0002);
        send_sample(16'hFFFF);
        drain();

        for (int p = 0; p < 10; p++)
        begin
            slope = ($urandom_range(3) == 0) ? SLOPE_W'($urandom)
                                             : SLOPE_W'($urandom_range(0, 24'h04_0000));
            thresh = SAMPLE_W'($urandom);
            case (p)
                0: slope = '0;
                1: slope = '1;
                2: thresh = '0;
                3: thresh = '1;
                4: slope = SLOPE_RESET;
                default: ;
            endcase
            set_curve(slope, thresh);
            stall_pct = (p % 4 == 0) ? 0 : (p % 4 == 1) ? 20 : (p % 4 == 2) ? 50 : 85;
            gap_max   = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 3 : 10;
            if (p == 2)
            begin
                gap_max = 0;
                hold_req = 1'b1;   // output held off while input keeps coming
            end
            for (int i = 0; i < 165; i++)
                send_sample(pick_sample(thresh));
            drain();
        end

        stall_pct = 0;
        repeat (DRAIN) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
